[rtl/rsa_pkg.sv]
// Shared types and constants for the ring slot allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package rsa_pkg;

  // Default number of message slots.
  localparam int unsigned SLOTS_DEF = 32;

  // Field widths.
  localparam int unsigned TIME_W = 64;
  localparam int unsigned PAY_W  = 64;
  localparam int unsigned IDX_W  = 5;

  // Packed stream widths, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 136;
  localparam int unsigned OUT_TDATA_W = 8;

  // Command codes carried in tuser.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_MARK = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the accepted item
    logic exec;  // carry out the captured item and register its result
  } rsa_cmd_t;

endpackage

[rtl/rsa_ram.sv]
// Generic single-port-write, registered-read RAM.
// Standalone; used by the datapath for the payload store.
module rsa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/rsa_ctrl.sv]
// Handshake controller for the ring slot allocator.
// Depends on rsa_pkg; drives the command struct into rsa_datapath.
module rsa_ctrl
  import rsa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rsa_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   exec_ok;

  // One item is held at a time; the result register may still be full.
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // The item executes once the result register is free or being emptied.
  assign exec_ok    = !out_valid_q || out_ready_i;
  assign cmd_o.load = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.exec = (state_q == ST_EXEC) && exec_ok;

  // State and result-valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EXEC;
          end
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_EXEC: begin
          if (exec_ok) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/rsa_datapath.sv]
// Datapath of the ring slot allocator: slot flag vectors, head pointer,
// free-slot search and result register. Depends on rsa_pkg and rsa_ram.
module rsa_datapath
  import rsa_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rsa_cmd_t          cmd_i,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_cmd_i,
  input  logic [TIME_W-1:0] in_time_i,
  input  logic              in_sent_i,
  input  logic [PAY_W-1:0]  in_payload_i,
  input  logic [IDX_W-1:0]  in_index_i,
  output logic [IDX_W-1:0]  slot_used_o,
  output logic              lost_unsent_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = (IW > IDX_W) ? IW : IDX_W;

  // Captured item; the timestamp only matters as zero or nonzero.
  logic             cmd_q;
  logic             time_nz_q;
  logic             sent_in_q;
  logic [PAY_W-1:0] pay_q;
  logic [IDX_W-1:0] idx_q;

  // Slot state.
  logic [SLOTS-1:0] nonempty_q;
  logic [SLOTS-1:0] sent_q;
  logic [IW-1:0]    head_q;
  logic             reuse_q;

  // Result register.
  logic [IDX_W-1:0] slot_used_q;
  logic             lost_q;

  // Search signals.
  logic [SLOTS-1:0] free_vec;
  logic [SLOTS-1:0] hi_free;
  logic [SLOTS-1:0] pick_src;
  logic [SLOTS-1:0] pick_low;
  logic [IW-1:0]    found_idx;
  logic [IW-1:0]    slot_sel;
  logic [IW-1:0]    head_next;
  logic [CW-1:0]    slot_ext;
  logic [CW:0]      idx_ext;
  logic             mark_ok;
  logic [IW-1:0]    mark_slot;
  logic             push_lost;
  logic             push_we;

  // Capture the accepted item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q     <= in_cmd_i;
      time_nz_q <= |in_time_i;
      sent_in_q <= in_sent_i;
      pay_q     <= in_payload_i;
      idx_q     <= in_index_i;
    end
  end

  // Free slots, and those at or above the head.
  always_comb begin
    free_vec = ~nonempty_q | sent_q;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      hi_free[i] = free_vec[i] && (IW'(i) >= head_q);
    end
  end

  // Lowest free slot, searching from the head first and wrapping to slot 0.
  always_comb begin
    pick_src  = (|hi_free) ? hi_free : free_vec;
    pick_low  = pick_src & (~pick_src + SLOTS'(1));
    found_idx = '0;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      if (pick_low[i]) begin
        found_idx = found_idx | IW'(i);
      end
    end
  end

  // Chosen slot for a push and the head that follows it.
  assign slot_sel  = (reuse_q && (|free_vec)) ? found_idx : head_q;
  assign head_next = (slot_sel == IW'(SLOTS - 1)) ? '0 : slot_sel + IW'(1);
  assign slot_ext  = CW'(slot_sel);
  assign push_lost = nonempty_q[slot_sel] && !sent_q[slot_sel];
  assign push_we   = cmd_i.exec && (cmd_q == CMD_PUSH);

  // Mark target; indices beyond the store are ignored.
  assign idx_ext   = (CW + 1)'(idx_q);
  assign mark_ok   = idx_ext < (CW + 1)'(SLOTS);
  assign mark_slot = idx_ext[IW-1:0];

  // Slot flags, head pointer and mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q <= '0;
      sent_q     <= '0;
      head_q     <= '0;
      reuse_q    <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        reuse_q <= cfg_wdata_i;
      end
      if (cmd_i.exec) begin
        if (cmd_q == CMD_MARK) begin
          if (mark_ok) begin
            sent_q[mark_slot] <= 1'b1;
          end
        end else begin
          nonempty_q[slot_sel] <= time_nz_q;
          sent_q[slot_sel]     <= sent_in_q;
          head_q               <= head_next;
        end
      end
    end
  end

  // Result register, loaded as the item executes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (cmd_q == CMD_MARK) begin
        slot_used_q <= idx_q;
        lost_q      <= 1'b0;
      end else begin
        slot_used_q <= slot_ext[IDX_W-1:0];
        lost_q      <= push_lost;
      end
    end
  end

  assign slot_used_o   = slot_used_q;
  assign lost_unsent_o = lost_q;

  // Payload store; its contents are kept but not returned in results.
  rsa_ram #(
    .WIDTH (PAY_W),
    .DEPTH (SLOTS),
    .AW    (IW)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (push_we),
    .waddr_i (slot_sel),
    .wdata_i (pay_q),
    .raddr_i (slot_sel),
    .rdata_o ()
  );

endmodule

[rtl/ring_slot_allocator_reuse_sent_unit.sv]
// Ring slot allocator: the accept edge captures the item, and once the result register
// is free or being emptied, a later edge runs the combinational rotating free-slot
// search and slot update and registers the result. No new item is accepted until the
// held item has executed. A held result delays the execution until the receiver takes it.
// Reset (rst_ni low, asynchronous) empties all slots, clears head, sets reuse mode.
module ring_slot_allocator_reuse_sent_unit
  import rsa_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration: reuse_sent_mode.
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  // Input items.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [63:0] created_time, [64] sent_flag, [128:65] payload, [133:129] slot_index
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] cmd
  input  logic                   s_axis_tuser,
  // Result items.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [4:0] slot_used, [5] lost_unsent, [7:6] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  rsa_cmd_t         ctrl_cmd;
  logic [IDX_W-1:0] slot_used;
  logic             lost_unsent;

  // Handshake controller.
  rsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (ctrl_cmd)
  );

  // Slot state and search.
  rsa_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_cmd_i      (s_axis_tuser),
    .in_time_i     (s_axis_tdata[63:0]),
    .in_sent_i     (s_axis_tdata[64]),
    .in_payload_i  (s_axis_tdata[128:65]),
    .in_index_i    (s_axis_tdata[133:129]),
    .slot_used_o   (slot_used),
    .lost_unsent_o (lost_unsent)
  );

  // Pack the result.
  assign m_axis_tdata = {2'b00, lost_unsent, slot_used};

`ifndef SYNTHESIS
  // Only one item is in flight: after an accept, the input side closes.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is still executing");

  // A pending result is never overwritten by a new execution.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.exec |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("result register overwritten while still pending");

  // A result appears only after an item was executed.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(ctrl_cmd.exec))
    else $error("result valid without an executed item");
`endif

endmodule
